>>> hw/rtl/hpe_pkg.sv
// Shared types, constants and helpers for the histogram percentile engine.
// Used by every module under hw/rtl except hpe_ram; depends on nothing.
package hpe_pkg;

  localparam int VALUE_BITS   = 12;
  localparam int COUNT_BITS   = 32;
  localparam int NUM_BINS     = 1 << VALUE_BITS;
  localparam int IN_VAL_BITS  = 12;
  localparam int OUT_VAL_BITS = 12;
  localparam int OUT_CNT_BITS = 32;
  localparam int POINT_BITS   = 10;
  localparam int SUM_BITS     = 44;
  localparam int SQ_BITS      = 55;
  localparam int SQ_OUT_BITS  = 54;
  localparam int EXT_BITS     = 18;
  localparam int SCALE        = 1000;
  localparam int SCALE_BITS   = 10;
  localparam int PROD_BITS    = COUNT_BITS + POINT_BITS;
  localparam int BIN_K_BITS   = COUNT_BITS + SCALE_BITS;
  localparam int SEEN_BITS    = COUNT_BITS + VALUE_BITS + SCALE_BITS;
  localparam int ACC_BITS     = COUNT_BITS + VALUE_BITS;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_PCT     = 2'd1,
    OP_ABOVE   = 2'd2,
    OP_SUMMARY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_LOAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic clr_wr;
    logic add_rd;
    logic add_wr;
    logic scan_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic pipe_busy;
  } sts_t;

  // Sign-extends or truncates a bin value to the 12-bit result fields.
  function automatic logic [OUT_VAL_BITS-1:0] to_out(input logic signed [VALUE_BITS-1:0] v);
    logic signed [EXT_BITS-1:0] e;
    e = EXT_BITS'(v);
    return e[OUT_VAL_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/hpe_ram.sv
// Generic simple dual-port RAM with registered read.
// Self-contained; no package dependency.
module hpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/hpe_ctrl.sv
// Controller state machine for the histogram percentile engine.
// Depends on hpe_pkg; drives commands into hpe_dp and reads its status.
module hpe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output hpe_pkg::cmd_t cmd,
  input  hpe_pkg::sts_t sts
);

  hpe_pkg::state_t st_r, st_nxt;
  hpe_pkg::op_t    op_in;

  assign op_in = hpe_pkg::op_t'(in_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hpe_pkg::ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      hpe_pkg::ST_CLEAR: if (sts.cnt_last) st_nxt = hpe_pkg::ST_IDLE;
      hpe_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (op_in)
            hpe_pkg::OP_ADD:     st_nxt = hpe_pkg::ST_ADD_RD;
            hpe_pkg::OP_PCT:     st_nxt = hpe_pkg::ST_SCAN;
            hpe_pkg::OP_ABOVE:   st_nxt = hpe_pkg::ST_SCAN;
            hpe_pkg::OP_SUMMARY: st_nxt = hpe_pkg::ST_LOAD;
            default:             st_nxt = hpe_pkg::ST_IDLE;
          endcase
        end
      end
      hpe_pkg::ST_ADD_RD: st_nxt = hpe_pkg::ST_ADD_WR;
      hpe_pkg::ST_ADD_WR: st_nxt = hpe_pkg::ST_IDLE;
      hpe_pkg::ST_SCAN:   if (sts.cnt_last) st_nxt = hpe_pkg::ST_DRAIN;
      hpe_pkg::ST_DRAIN:  if (!sts.pipe_busy) st_nxt = hpe_pkg::ST_LOAD;
      hpe_pkg::ST_LOAD:   st_nxt = hpe_pkg::ST_OUT;
      hpe_pkg::ST_OUT:    if (!out_stall) st_nxt = hpe_pkg::ST_IDLE;
      default:            st_nxt = hpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (st_r)
      hpe_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
      hpe_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      hpe_pkg::ST_ADD_RD: cmd.add_rd   = 1'b1;
      hpe_pkg::ST_ADD_WR: cmd.add_wr   = 1'b1;
      hpe_pkg::ST_SCAN:   cmd.scan_rd  = 1'b1;
      hpe_pkg::ST_DRAIN:  cmd          = '0;
      hpe_pkg::ST_LOAD:   cmd.out_load = 1'b1;
      hpe_pkg::ST_OUT:    out_valid    = 1'b1;
      default:            cmd          = '0;
    endcase
  end

  // An add goes through its read and write-back states and returns to idle.
  a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && op_in == hpe_pkg::OP_ADD) |-> ##3 (st_r == hpe_pkg::ST_IDLE))
    else $error("add did not return to idle");

  // A summary query passes through the load state and then shows its result.
  a_summary_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && op_in == hpe_pkg::OP_SUMMARY) |-> ##2 out_valid)
    else $error("summary result late");

  // Bin writes and scan reads never share a cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add_wr || cmd.clr_wr) |-> !cmd.scan_rd)
    else $error("write during scan");

endmodule

>>> hw/rtl/hpe_dp.sv
// Datapath of the histogram percentile engine: bin memory, running totals,
// the bin scan pipeline and the result register. Depends on hpe_pkg, hpe_ram.
module hpe_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  hpe_pkg::cmd_t                          cmd,
  output hpe_pkg::sts_t                          sts,
  input  logic [1:0]                             in_op,
  input  logic signed [hpe_pkg::IN_VAL_BITS-1:0] in_value,
  input  logic [hpe_pkg::POINT_BITS-1:0]         in_point_per_mille,
  output logic signed [hpe_pkg::OUT_VAL_BITS-1:0] out_percentile_value,
  output logic [hpe_pkg::OUT_CNT_BITS-1:0]       out_count_above,
  output logic [hpe_pkg::OUT_CNT_BITS-1:0]       out_sample_count,
  output logic signed [hpe_pkg::SUM_BITS-1:0]    out_sample_sum,
  output logic [hpe_pkg::SQ_OUT_BITS-1:0]        out_sum_of_squares,
  output logic signed [hpe_pkg::OUT_VAL_BITS-1:0] out_min_value,
  output logic signed [hpe_pkg::OUT_VAL_BITS-1:0] out_max_value
);

  localparam int VB = hpe_pkg::VALUE_BITS;
  localparam int CB = hpe_pkg::COUNT_BITS;
  localparam int EB = hpe_pkg::EXT_BITS;
  localparam logic signed [EB-1:0] VMIN_E = EB'(-(2 ** (VB - 1)));
  localparam logic signed [EB-1:0] VMAX_E = EB'((2 ** (VB - 1)) - 1);
  localparam logic [CB-1:0] CNT_MAX = '1;
  localparam logic [hpe_pkg::OUT_CNT_BITS-1:0] OUT_MAX = '1;

  // Shared bin address counter for the clearing pass and the scans.
  logic [VB-1:0] cnt_r;

  // Item register.
  hpe_pkg::op_t                op_r;
  logic signed [VB-1:0]        v_r;
  logic [VB-1:0]               idx_r;
  logic [VB:0]                 start_r;
  logic [hpe_pkg::PROD_BITS-1:0] ptot_r;
  logic [2*VB-1:0]             sq_r;

  // Totals.
  logic [CB-1:0]                    total_r;
  logic [hpe_pkg::SUM_BITS-1:0]     sum_r;
  logic [hpe_pkg::SQ_BITS-1:0]      sqsum_r;
  logic signed [VB-1:0]             min_r, max_r;

  // Scan pipeline.
  logic                             s1_v_r, s2_v_r;
  logic [VB-1:0]                    s1_idx_r, s2_idx_r;
  logic [CB-1:0]                    s2_bin_r;
  logic [hpe_pkg::BIN_K_BITS-1:0]   s2_bink_r;
  logic [hpe_pkg::SEEN_BITS-1:0]    seen_r, seen_sum;
  logic [hpe_pkg::ACC_BITS-1:0]     acc_r;
  logic                             found_r;
  logic signed [VB-1:0]             pct_r;

  // Memory port.
  logic          ram_we, ram_re;
  logic [VB-1:0] ram_waddr, ram_raddr;
  logic [CB-1:0] ram_wdata, ram_rdata;
  logic [hpe_pkg::BIN_K_BITS-1:0] rd_k;

  // Take-time values.
  logic signed [EB-1:0] val_e;
  logic signed [VB-1:0] val_cl;
  logic [VB:0]          start_nxt;
  logic [EB-1:0]        start_e;

  hpe_ram #(.WIDTH(CB), .DEPTH(hpe_pkg::NUM_BINS)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we    = cmd.clr_wr || cmd.add_wr;
  assign ram_waddr = cmd.clr_wr ? cnt_r : idx_r;
  assign ram_wdata = cmd.clr_wr ? '0 :
                     (ram_rdata == CNT_MAX) ? ram_rdata : ram_rdata + CB'(1);
  assign ram_re    = cmd.add_rd || cmd.scan_rd;
  assign ram_raddr = cmd.scan_rd ? cnt_r : idx_r;

  assign sts.cnt_last  = (cnt_r == VB'(hpe_pkg::NUM_BINS - 1));
  assign sts.pipe_busy = s1_v_r || s2_v_r;

  always_comb begin
    val_e = EB'(in_value);
    if (val_e < VMIN_E) begin
      val_cl = VMIN_E[VB-1:0];
    end else if (val_e > VMAX_E) begin
      val_cl = VMAX_E[VB-1:0];
    end else begin
      val_cl = val_e[VB-1:0];
    end
    // First bin counted by a count-above query; past the top means none.
    start_e = EB'(val_e - VMIN_E + EB'(1));
    if (val_e >= VMAX_E) begin
      start_nxt = (VB + 1)'(hpe_pkg::NUM_BINS);
    end else if (val_e < VMIN_E) begin
      start_nxt = '0;
    end else begin
      start_nxt = start_e[VB:0];
    end
  end

  // Bin count times 1000 as shifts and subtracts.
  assign rd_k = (hpe_pkg::BIN_K_BITS'(ram_rdata) << 10)
              - (hpe_pkg::BIN_K_BITS'(ram_rdata) << 4)
              - (hpe_pkg::BIN_K_BITS'(ram_rdata) << 3);

  // seen >= ceil(p*T/1000) is the same test as seen*1000 >= p*T.
  assign seen_sum = seen_r + hpe_pkg::SEEN_BITS'(s2_bink_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      total_r <= '0;
      sum_r   <= '0;
      sqsum_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      s1_v_r <= cmd.scan_rd;
      s2_v_r <= s1_v_r;
      if (cmd.take) begin
        cnt_r <= '0;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
        cnt_r <= cnt_r + VB'(1);
      end
      if (cmd.add_wr) begin
        if (total_r != CNT_MAX) total_r <= total_r + CB'(1);
        if (total_r == '0) begin
          min_r <= v_r;
          max_r <= v_r;
        end else begin
          if (v_r < min_r) min_r <= v_r;
          if (v_r > max_r) max_r <= v_r;
        end
        sum_r   <= sum_r + hpe_pkg::SUM_BITS'(v_r);
        sqsum_r <= sqsum_r + hpe_pkg::SQ_BITS'(sq_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r    <= hpe_pkg::op_t'(in_op);
      v_r     <= val_cl;
      idx_r   <= {~val_cl[VB-1], val_cl[VB-2:0]};
      start_r <= start_nxt;
      ptot_r  <= hpe_pkg::PROD_BITS'(in_point_per_mille) * hpe_pkg::PROD_BITS'(total_r);
      seen_r  <= '0;
      acc_r   <= '0;
      found_r <= 1'b0;
      pct_r   <= '0;
    end else if (s2_v_r) begin
      seen_r <= seen_sum;
      if (!found_r && s2_bin_r != '0 &&
          seen_sum >= hpe_pkg::SEEN_BITS'(ptot_r)) begin
        found_r <= 1'b1;
        pct_r   <= {~s2_idx_r[VB-1], s2_idx_r[VB-2:0]};
      end
      if ({1'b0, s2_idx_r} >= start_r) begin
        acc_r <= acc_r + hpe_pkg::ACC_BITS'(s2_bin_r);
      end
    end
    if (cmd.add_rd) begin
      sq_r <= (2*VB)'(v_r * v_r);
    end
    s1_idx_r  <= cnt_r;
    s2_idx_r  <= s1_idx_r;
    s2_bin_r  <= ram_rdata;
    s2_bink_r <= rd_k;
    if (cmd.out_load) begin
      out_percentile_value <= '0;
      out_count_above      <= '0;
      out_sample_count     <= '0;
      out_sample_sum       <= '0;
      out_sum_of_squares   <= '0;
      out_min_value        <= '0;
      out_max_value        <= '0;
      unique case (op_r)
        hpe_pkg::OP_PCT: begin
          if (total_r != '0) begin
            out_percentile_value <= hpe_pkg::to_out(found_r ? pct_r : max_r);
          end
        end
        hpe_pkg::OP_ABOVE: begin
          out_count_above <= (acc_r > hpe_pkg::ACC_BITS'(OUT_MAX)) ? OUT_MAX :
                             acc_r[hpe_pkg::OUT_CNT_BITS-1:0];
        end
        hpe_pkg::OP_SUMMARY: begin
          out_sample_count <= (hpe_pkg::ACC_BITS'(total_r) >
                               hpe_pkg::ACC_BITS'(OUT_MAX)) ? OUT_MAX :
                              hpe_pkg::OUT_CNT_BITS'(total_r);
          out_sample_sum     <= sum_r;
          out_sum_of_squares <= sqsum_r[hpe_pkg::SQ_OUT_BITS-1:0];
          if (total_r != '0) begin
            out_min_value <= hpe_pkg::to_out(min_r);
            out_max_value <= hpe_pkg::to_out(max_r);
          end
        end
        default: out_percentile_value <= '0;
      endcase
    end
  end

endmodule

>>> hw/rtl/histogram_percentile_engine_unit.sv
// Histogram percentile engine: one 32-bit counter per 12-bit sample value in
// a 4096-entry RAM, plus count, sum, sum of squares, min and max. After reset
// the block clears the bin RAM one entry a cycle with in_stall high. One item
// is worked at a time: an add reads the RAM, then writes back the incremented
// bin; a summary query loads the result register after the transfer and then
// shows its result; percentile and count-above queries read every bin through
// the single RAM read port, drain the scan pipeline and then load the result.
// The block takes a new item once an add has written back or a query result
// is transferred out. Depends on hpe_pkg, hpe_ctrl, hpe_dp and hpe_ram.
module histogram_percentile_engine_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_op,
  input  logic signed [hpe_pkg::IN_VAL_BITS-1:0]  in_value,
  input  logic [hpe_pkg::POINT_BITS-1:0]          in_point_per_mille,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [hpe_pkg::OUT_VAL_BITS-1:0] out_percentile_value,
  output logic [hpe_pkg::OUT_CNT_BITS-1:0]        out_count_above,
  output logic [hpe_pkg::OUT_CNT_BITS-1:0]        out_sample_count,
  output logic signed [hpe_pkg::SUM_BITS-1:0]     out_sample_sum,
  output logic [hpe_pkg::SQ_OUT_BITS-1:0]         out_sum_of_squares,
  output logic signed [hpe_pkg::OUT_VAL_BITS-1:0] out_min_value,
  output logic signed [hpe_pkg::OUT_VAL_BITS-1:0] out_max_value
);

  hpe_pkg::cmd_t cmd;
  hpe_pkg::sts_t sts;

  hpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  hpe_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_op                (in_op),
    .in_value             (in_value),
    .in_point_per_mille   (in_point_per_mille),
    .out_percentile_value (out_percentile_value),
    .out_count_above      (out_count_above),
    .out_sample_count     (out_sample_count),
    .out_sample_sum       (out_sample_sum),
    .out_sum_of_squares   (out_sum_of_squares),
    .out_min_value        (out_min_value),
    .out_max_value        (out_max_value)
  );

endmodule

>>> bench/histogram_percentile_engine_unit_tb.sv
// Self-checking testbench for histogram_percentile_engine_unit: directed and random
// adds and queries, with a scoreboard that keeps its own histogram.
// Depends on hpe_pkg and the histogram_percentile_engine_unit RTL.
module histogram_percentile_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] pct;
    logic [31:0] above;
    logic [31:0] count;
    logic [43:0] sum;
    logic [53:0] squares;
    logic [11:0] min_v;
    logic [11:0] max_v;
  } stats_rec_t;

  class hist_scoreboard;
    int unsigned bin_cnt[hpe_pkg::NUM_BINS];
    logic [31:0] total;
    logic [43:0] sum_acc;
    logic [54:0] sq_acc;
    logic signed [11:0] lowest;
    logic signed [11:0] highest;
    stats_rec_t pending[$];
    int errors;

    function new();
      foreach (bin_cnt[i]) bin_cnt[i] = 0;
      total = 0;
      sum_acc = 0;
      sq_acc = 0;
      lowest = 0;
      highest = 0;
      errors = 0;
    endfunction

    function logic [11:0] percentile(logic [9:0] point);
      longint unsigned rank;
      longint unsigned seen;
      seen = 0;
      if (total == 0) return 0;
      rank = (longint'(point) * longint'(total) + 999) / 1000;
      if (rank == 0) rank = 1;
      for (int i = 0; i < hpe_pkg::NUM_BINS; i++) begin
        seen += bin_cnt[i];
        if (bin_cnt[i] != 0 && seen >= rank) return 12'(i - 2048);
      end
      return highest;
    endfunction

    function logic [31:0] above(logic signed [11:0] thr);
      longint unsigned acc;
      acc = 0;
      if (thr == 12'sd2047) return 0;
      for (int v = int'(thr) + 1; v <= 2047; v++) acc += bin_cnt[v + 2048];
      return (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(acc);
    endfunction

    // Called at each input transfer; queries queue their expected result.
    function void note_transfer(hpe_pkg::op_t op, logic signed [11:0] v, logic [9:0] point);
      stats_rec_t r;
      longint sq;
      r = '0;
      sq = longint'(v) * longint'(v);
      case (op)
        hpe_pkg::OP_ADD: begin
          if (bin_cnt[int'(v) + 2048] != 32'hFFFF_FFFF) bin_cnt[int'(v) + 2048]++;
          if (total == 0) begin
            lowest = v;
            highest = v;
          end else begin
            if (v < lowest) lowest = v;
            if (v > highest) highest = v;
          end
          if (total != 32'hFFFF_FFFF) total++;
          sum_acc = sum_acc + 44'(longint'(v));
          sq_acc = sq_acc + 55'(sq);
        end
        hpe_pkg::OP_PCT: begin
          r.pct = percentile(point);
          pending = {pending, r};
        end
        hpe_pkg::OP_ABOVE: begin
          r.above = above(v);
          pending = {pending, r};
        end
        default: begin
          r.count = total;
          r.sum = sum_acc;
          r.squares = sq_acc[53:0];
          r.min_v = (total != 0) ? lowest : 12'd0;
          r.max_v = (total != 0) ? highest : 12'd0;
          pending = {pending, r};
        end
      endcase
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      errors++;
    endtask

    task check_result(stats_rec_t got);
      stats_rec_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 64'(got.count), 0);
        return;
      end
      want = pending.pop_front();
      if (got.pct !== want.pct) report("percentile_value", got.pct, want.pct);
      if (got.above !== want.above) report("count_above", got.above, want.above);
      if (got.count !== want.count) report("sample_count", got.count, want.count);
      if (got.sum !== want.sum) report("sample_sum", got.sum, want.sum);
      if (got.squares !== want.squares) report("sum_of_squares", got.squares, want.squares);
      if (got.min_v !== want.min_v) report("min_value", got.min_v, want.min_v);
      if (got.max_v !== want.max_v) report("max_value", got.max_v, want.max_v);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_op = hpe_pkg::OP_ADD;
  logic signed [11:0] in_value = 0;
  logic [9:0] in_point_per_mille = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [11:0] out_percentile_value;
  logic [31:0] out_count_above;
  logic [31:0] out_sample_count;
  logic signed [43:0] out_sample_sum;
  logic [53:0] out_sum_of_squares;
  logic signed [11:0] out_min_value;
  logic signed [11:0] out_max_value;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  hist_scoreboard sb = new();

  histogram_percentile_engine_unit dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Result side: check each transfer, then pick the next stall value.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_percentile_value, out_count_above, out_sample_count,
                       out_sample_sum, out_sum_of_squares, out_min_value, out_max_value});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task send(hpe_pkg::op_t op, logic signed [11:0] v, logic [9:0] point);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1;
    in_op <= op;
    in_value <= v;
    in_point_per_mille <= point;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(op, v, point);
  endtask

  task send_random(int n);
    int pick;
    logic signed [11:0] v;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      v = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 12'sd2047 : -12'sd2048)
                                    : 12'($urandom);
      if (pick < 3) send(hpe_pkg::OP_PCT, v, 10'($urandom_range(1023)));
      else if (pick < 6) send(hpe_pkg::OP_ABOVE, v, 10'($urandom));
      else if (pick < 22) send(hpe_pkg::OP_SUMMARY, v, 10'($urandom));
      else send(hpe_pkg::OP_ADD, v, 10'($urandom));
    end
  endtask

  task drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    // Empty histogram first, then the extremes of the input value and per-mille point.
    send(hpe_pkg::OP_SUMMARY, 0, 0);
    send(hpe_pkg::OP_PCT, 0, 10'd500);
    send(hpe_pkg::OP_ABOVE, -12'sd2048, 0);
    send(hpe_pkg::OP_ADD, -12'sd2048, 10'h3FF);
    send(hpe_pkg::OP_ADD, 12'sd2047, 0);
    send(hpe_pkg::OP_ADD, 0, 0);
    send(hpe_pkg::OP_ADD, -12'sd1, 0);
    send(hpe_pkg::OP_ADD, 12'sd1, 0);
    send(hpe_pkg::OP_ADD, 12'sd2047, 0);
    send(hpe_pkg::OP_SUMMARY, 12'sd2047, 10'h3FF);
    send(hpe_pkg::OP_PCT, 0, 10'd0);
    send(hpe_pkg::OP_PCT, 0, 10'd1);
    send(hpe_pkg::OP_PCT, 0, 10'd999);
    send(hpe_pkg::OP_PCT, 0, 10'd1000);
    send(hpe_pkg::OP_PCT, 0, 10'd1023);
    send(hpe_pkg::OP_ABOVE, -12'sd2048, 0);
    send(hpe_pkg::OP_ABOVE, -12'sd1, 0);
    send(hpe_pkg::OP_ABOVE, 12'sd2046, 0);
    send(hpe_pkg::OP_ABOVE, 12'sd2047, 0);
    send(hpe_pkg::OP_SUMMARY, 0, 0);
    send_random(110);
    send_idle_pct = 88;
    send_random(110);
    send_idle_pct = 0;
    recv_stall_pct = 88;
    send_random(110);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    send_random(110);
    // Long receiver hold-off while summaries keep coming, so the input backs up.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    hold_cycles = 300;
    for (int i = 0; i < 6; i++) send(hpe_pkg::OP_SUMMARY, 0, 0);
    send_random(40);
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
